// ===== sv/lkt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkt_pkg: shared types and constants of the reader/writer lock table
// request and status codes, table update command and default sizes
// ----------------------------------------------------------------------------
package lkt_pkg;

   // default sizes
   localparam int Entries   = 8;
   localparam int KeyBits   = 16;
   localparam int CountBits = 8;

   // fixed field widths of the request and response ports
   localparam int KeyPortBits = 16;
   localparam int KeyMaxBits  = 32;
   localparam int StatusBits  = 3;

   // request action
   localparam logic ActAcquire = 1'b0;
   localparam logic ActRelease = 1'b1;

   // request mode
   localparam logic ModeRead  = 1'b0;
   localparam logic ModeWrite = 1'b1;

   // response status
   localparam logic [StatusBits-1:0] StGranted  = 3'd0;
   localparam logic [StatusBits-1:0] StConflict = 3'd1;
   localparam logic [StatusBits-1:0] StFull     = 3'd2;
   localparam logic [StatusBits-1:0] StReleased = 3'd3;
   localparam logic [StatusBits-1:0] StIgnored  = 3'd4;

   // table update operations
   localparam logic [1:0] OpNone  = 2'd0;
   localparam logic [1:0] OpClaim = 2'd1;
   localparam logic [1:0] OpBump  = 2'd2;
   localparam logic [1:0] OpDrop  = 2'd3;

   // update command sent to the entry storage
   typedef struct packed {
      logic [1:0] op;
      logic       mode;
   } upd_type;

endpackage
`default_nettype wire

// ===== sv/lkt_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkt_search: parallel key compare and free entry search
// returns the lowest matching used entry and the lowest free entry, one-hot
// ----------------------------------------------------------------------------
module lkt_search #(
   parameter int ENTRIES  = lkt_pkg::Entries,
   parameter int KEY_BITS = lkt_pkg::KeyBits
) (
   input  wire logic [ENTRIES-1:0]                used,
   input  wire logic [ENTRIES-1:0][KEY_BITS-1:0]  keys,
   input  wire logic [KEY_BITS-1:0]               key,
   output logic      [ENTRIES-1:0]                hit_sel,
   output logic      [ENTRIES-1:0]                free_sel
);

   logic [ENTRIES-1:0] hit_raw;
   logic [ENTRIES-1:0] free_raw;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_raw[i] = used[i] && (keys[i] == key);
      end
   end

   assign free_raw = ~used;

   // isolate the lowest set bit
   assign hit_sel  = hit_raw & (~hit_raw + ENTRIES'(1));
   assign free_sel = free_raw & (~free_raw + ENTRIES'(1));

endmodule
`default_nettype wire

// ===== sv/lkt_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkt_table: lock entry storage
// used bits, keys, modes and holder counts, one entry updated per cycle
// ----------------------------------------------------------------------------
module lkt_table #(
   parameter int ENTRIES    = lkt_pkg::Entries,
   parameter int KEY_BITS   = lkt_pkg::KeyBits,
   parameter int COUNT_BITS = lkt_pkg::CountBits
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lkt_pkg::upd_type                      upd,
   input  wire logic [ENTRIES-1:0]                    sel,
   input  wire logic [KEY_BITS-1:0]                   key,
   output logic      [ENTRIES-1:0]                    used,
   output logic      [ENTRIES-1:0]                    excl,
   output logic      [ENTRIES-1:0][KEY_BITS-1:0]      keys,
   output logic      [ENTRIES-1:0][COUNT_BITS-1:0]    holders
);

   logic [ENTRIES-1:0]                 used_ff,    used_in;
   logic [ENTRIES-1:0]                 excl_ff,    excl_in;
   logic [ENTRIES-1:0][KEY_BITS-1:0]   key_ff,     key_in;
   logic [ENTRIES-1:0][COUNT_BITS-1:0] holders_ff, holders_in;

   always_comb begin
      used_in    = used_ff;
      excl_in    = excl_ff;
      key_in     = key_ff;
      holders_in = holders_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i]) begin
            unique case (upd.op)
               lkt_pkg::OpClaim: begin
                  used_in[i]    = 1'b1;
                  excl_in[i]    = upd.mode;
                  key_in[i]     = key;
                  holders_in[i] = COUNT_BITS'(1);
               end
               lkt_pkg::OpBump: begin
                  holders_in[i] = holders_ff[i] + COUNT_BITS'(1);
               end
               lkt_pkg::OpDrop: begin
                  if (holders_ff[i] <= COUNT_BITS'(1)) begin
                     used_in[i]    = 1'b0;
                     holders_in[i] = '0;
                  end else begin
                     holders_in[i] = holders_ff[i] - COUNT_BITS'(1);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      excl_ff    <= excl_in;
      key_ff     <= key_in;
      holders_ff <= holders_in;
   end

   assign used    = used_ff;
   assign excl    = excl_ff;
   assign keys    = key_ff;
   assign holders = holders_ff;

endmodule
`default_nettype wire

// ===== sv/reader_writer_lock_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reader_writer_lock_table: reader/writer lock table
// fixed set of lock entries; acquire and release requests, one status each
// ----------------------------------------------------------------------------
// usage
//   a request beat is taken at a rising edge with start high and busy low;
//   it carries req_action (acquire/release), req_key and req_mode
//   (shared read/exclusive write)
//   every request gives exactly one response beat: rsp_valid is high for one
//   cycle with rsp_status, and the receiver takes it at the edge ending that
//   cycle; there is no way to hold a response off
//   path: a request passes the request register, where the table is
//   searched and the decision is made, and then the response register,
//   whose output is the response beat
//   throughput: one request per cycle while busy is low; all entries are
//   compared in parallel in one pass and one entry is written at the response
//   edge, so the next request already sees the updated table
//   reset: synchronous, active high; every entry becomes free, pending
//   beats are dropped, and busy stays high until the first cycle after reset
// ----------------------------------------------------------------------------
module reader_writer_lock_table #(
   parameter int ENTRIES    = lkt_pkg::Entries,
   parameter int KEY_BITS   = lkt_pkg::KeyBits,
   parameter int COUNT_BITS = lkt_pkg::CountBits
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_action,
   input  wire logic [lkt_pkg::KeyPortBits-1:0] req_key,
   input  wire logic                            req_mode,
   output logic                                 rsp_valid,
   output logic [lkt_pkg::StatusBits-1:0]       rsp_status
);

   localparam int ExtPad = lkt_pkg::KeyMaxBits - lkt_pkg::KeyPortBits;

   // busy only around reset
   logic busy_ff;

   // request register
   logic                stg_valid_ff;
   logic                stg_action_ff;
   logic                stg_mode_ff;
   logic [KEY_BITS-1:0] stg_key_ff;

   // response register
   logic                            rsp_valid_ff;
   logic [lkt_pkg::StatusBits-1:0]  rsp_status_ff, rsp_status_in;

   // table view
   logic [ENTRIES-1:0]                 used;
   logic [ENTRIES-1:0]                 excl;
   logic [ENTRIES-1:0][KEY_BITS-1:0]   keys;
   logic [ENTRIES-1:0][COUNT_BITS-1:0] holders;
   logic [ENTRIES-1:0]                 hit_sel;
   logic [ENTRIES-1:0]                 free_sel;

   logic                               hit;
   logic                               free_found;
   logic                               hit_excl;
   logic [COUNT_BITS-1:0]              hit_count;

   logic [lkt_pkg::KeyMaxBits-1:0]     key_ext;
   logic                               accept;

   lkt_pkg::upd_type                   upd;
   logic [ENTRIES-1:0]                 upd_sel;

   assign accept  = start && !busy_ff;
   // only the low KEY_BITS bits of the key take part
   assign key_ext = {{ExtPad{1'b0}}, req_key};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         stg_valid_ff <= accept;
         rsp_valid_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_action_ff <= req_action;
         stg_mode_ff   <= req_mode;
         stg_key_ff    <= key_ext[KEY_BITS-1:0];
      end
      rsp_status_ff <= rsp_status_in;
   end

   lkt_search #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_search (
      .used     (used),
      .keys     (keys),
      .key      (stg_key_ff),
      .hit_sel  (hit_sel),
      .free_sel (free_sel)
   );

   // count of the matching entry
   always_comb begin
      hit_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_count = hit_count | (holders[i] & {COUNT_BITS{hit_sel[i]}});
      end
   end

   assign hit        = |hit_sel;
   assign free_found = |free_sel;
   assign hit_excl   = |(hit_sel & excl);

   // decision for the request in the stage register
   always_comb begin
      upd.op        = lkt_pkg::OpNone;
      upd.mode      = stg_mode_ff;
      upd_sel       = hit_sel;
      rsp_status_in = lkt_pkg::StIgnored;
      if (stg_action_ff == lkt_pkg::ActAcquire) begin
         if (hit) begin
            if (!hit_excl && (stg_mode_ff == lkt_pkg::ModeRead)) begin
               // shared read joins readers unless the count is saturated
               if (&hit_count) begin
                  rsp_status_in = lkt_pkg::StFull;
               end else begin
                  rsp_status_in = lkt_pkg::StGranted;
                  upd.op        = lkt_pkg::OpBump;
               end
            end else begin
               rsp_status_in = lkt_pkg::StConflict;
            end
         end else if (free_found) begin
            // new key takes the lowest free entry
            rsp_status_in = lkt_pkg::StGranted;
            upd.op        = lkt_pkg::OpClaim;
            upd_sel       = free_sel;
         end else begin
            rsp_status_in = lkt_pkg::StFull;
         end
      end else begin
         if (hit && (hit_excl == stg_mode_ff)) begin
            rsp_status_in = lkt_pkg::StReleased;
            upd.op        = lkt_pkg::OpDrop;
         end
      end
      // no table write without a live request
      if (!stg_valid_ff) begin
         upd.op = lkt_pkg::OpNone;
      end
   end

   lkt_table #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .sel     (upd_sel),
      .key     (stg_key_ff),
      .used    (used),
      .excl    (excl),
      .keys    (keys),
      .holders (holders)
   );

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

// ===== sv/lkt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkt_checker: port level checks of the lock table
// response timing and status classes seen on the top level ports
// ----------------------------------------------------------------------------
module lkt_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            req_action,
   input wire logic [lkt_pkg::KeyPortBits-1:0] req_key,
   input wire logic                            req_mode,
   input wire logic                            rsp_valid,
   input wire logic [lkt_pkg::StatusBits-1:0]  rsp_status
);

   logic take;
   assign take = start && !busy;

   // every request beat gives a response beat once past the request and response registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> ##1 rsp_valid)
      else $error("response beat missing");

   // no response beat without a request beat before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, 2))
      else $error("response beat without request");

   // acquire answers only grant, conflict or full
   a_acquire_status: assert property (@(posedge clock) disable iff (reset)
      (take && req_action == lkt_pkg::ActAcquire) |=> ##1
         (rsp_status == lkt_pkg::StGranted || rsp_status == lkt_pkg::StConflict ||
          rsp_status == lkt_pkg::StFull))
      else $error("bad acquire status");

   // release answers only released or ignored
   a_release_status: assert property (@(posedge clock) disable iff (reset)
      (take && req_action == lkt_pkg::ActRelease) |=> ##1
         (rsp_status == lkt_pkg::StReleased || rsp_status == lkt_pkg::StIgnored))
      else $error("bad release status");

   // a write acquire directly followed by a write acquire of the same key:
   // the second one is never granted
   a_write_excludes: assert property (@(posedge clock) disable iff (reset)
      (take && req_action == lkt_pkg::ActAcquire && req_mode == lkt_pkg::ModeWrite)
      ##1 (take && req_action == lkt_pkg::ActAcquire &&
           req_mode == lkt_pkg::ModeWrite && req_key == $past(req_key))
      |=> ##1 (rsp_valid && rsp_status != lkt_pkg::StGranted))
      else $error("second holder granted on write lock");

endmodule

bind reader_writer_lock_table lkt_checker u_lkt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_action (req_action),
   .req_key    (req_key),
   .req_mode   (req_mode),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);
`default_nettype wire
